// File: rtl/assert_macros.svh
// Assertion macros used by the checker file ami_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define AMI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define AMI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/ami_pkg.sv
// Types and constants for the affine matrix inverse block.
// No dependencies.
package ami_pkg;
   localparam int LANES     = 6;
   localparam int FIELD_W   = 32;
   localparam int DET_W     = 64;
   localparam int NUM_W     = 80;
   localparam int QUO_W     = 33;
   localparam int REM_W     = NUM_W + 17;
   localparam int DIV_STEPS = QUO_W;
   localparam int TDATA_W   = LANES * FIELD_W;
   localparam int TUSER_W   = 2;

   typedef struct packed {
      logic                             singular;
      logic                             det_neg;
      logic [DET_W-1:0]                 det_mag;
      logic [LANES-1:0]                 num_neg;
      logic [LANES-1:0][NUM_W-1:0]      num_mag;
   } job_type;

   typedef struct packed {
      logic                             valid;
      logic                             singular;
      logic [DET_W-1:0]                 det_mag;
      logic [LANES-1:0]                 neg;
      logic [LANES-1:0]                 ovf;
      logic [LANES-1:0][REM_W-1:0]      rem;
      logic [LANES-1:0][QUO_W-1:0]      quo;
   } div_stage_type;
endpackage

// File: rtl/ami_front.sv
// Front part: products, determinant and numerators of one matrix word.
// Depends on ami_pkg.
module ami_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [ami_pkg::TDATA_W-1:0] in_data,
   output logic                   out_valid,
   output ami_pkg::job_type       out_job
);
   logic        v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [63:0] p_ae_ff, p_bd_ff, p_bf_ff, p_ce_ff, p_cd_ff, p_af_ff;
   logic signed [31:0] a_ff, b_ff, d_ff, e_ff;
   logic signed [64:0] det_ff, det_in, t2_ff, t2_in, t5_ff, t5_in;
   logic signed [32:0] n0_ff, n1_ff, n3_ff, n4_ff;
   logic signed [32:0] n0_in, n1_in, n3_in, n4_in;
   ami_pkg::job_type   job_ff, job_in;
   logic signed [31:0] fa, fb, fc, fd, fe, ff;
   logic [64:0] det_abs, t2_abs, t5_abs;
   logic [32:0] n0_abs, n1_abs, n3_abs, n4_abs;

   assign fa = in_data[31:0];
   assign fb = in_data[63:32];
   assign fc = in_data[95:64];
   assign fd = in_data[127:96];
   assign fe = in_data[159:128];
   assign ff = in_data[191:160];

   assign v1_in = in_valid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_comb begin
      det_in = {p_ae_ff[63], p_ae_ff} - {p_bd_ff[63], p_bd_ff};
      t2_in  = {p_bf_ff[63], p_bf_ff} - {p_ce_ff[63], p_ce_ff};
      t5_in  = {p_cd_ff[63], p_cd_ff} - {p_af_ff[63], p_af_ff};
      n0_in  = {e_ff[31], e_ff};
      n1_in  = 33'sd0 - {b_ff[31], b_ff};
      n3_in  = 33'sd0 - {d_ff[31], d_ff};
      n4_in  = {a_ff[31], a_ff};
   end

   always_comb begin
      det_abs = det_ff[64] ? 65'(-det_ff) : 65'(det_ff);
      t2_abs  = t2_ff[64]  ? 65'(-t2_ff)  : 65'(t2_ff);
      t5_abs  = t5_ff[64]  ? 65'(-t5_ff)  : 65'(t5_ff);
      n0_abs  = n0_ff[32]  ? 33'(-n0_ff)  : 33'(n0_ff);
      n1_abs  = n1_ff[32]  ? 33'(-n1_ff)  : 33'(n1_ff);
      n3_abs  = n3_ff[32]  ? 33'(-n3_ff)  : 33'(n3_ff);
      n4_abs  = n4_ff[32]  ? 33'(-n4_ff)  : 33'(n4_ff);
      job_in.singular   = (det_ff == 65'sd0);
      job_in.det_neg    = det_ff[64];
      job_in.det_mag    = det_abs[63:0];
      job_in.num_neg    = {t5_ff[64], n4_ff[32], n3_ff[32],
                           t2_ff[64], n1_ff[32], n0_ff[32]};
      job_in.num_mag[0] = {16'd0, n0_abs[31:0], 32'd0};
      job_in.num_mag[1] = {16'd0, n1_abs[31:0], 32'd0};
      job_in.num_mag[2] = {t2_abs[63:0], 16'd0};
      job_in.num_mag[3] = {16'd0, n3_abs[31:0], 32'd0};
      job_in.num_mag[4] = {16'd0, n4_abs[31:0], 32'd0};
      job_in.num_mag[5] = {t5_abs[63:0], 16'd0};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ae_ff <= fa * fe;
         p_bd_ff <= fb * fd;
         p_bf_ff <= fb * ff;
         p_ce_ff <= fc * fe;
         p_cd_ff <= fc * fd;
         p_af_ff <= fa * ff;
         a_ff    <= fa;
         b_ff    <= fb;
         d_ff    <= fd;
         e_ff    <= fe;
         det_ff  <= det_in;
         t2_ff   <= t2_in;
         t5_ff   <= t5_in;
         n0_ff   <= n0_in;
         n1_ff   <= n1_in;
         n3_ff   <= n3_in;
         n4_ff   <= n4_in;
         job_ff  <= job_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_job   = job_ff;
endmodule

// File: rtl/ami_queue.sv
// Short queue of prepared division jobs between front and back.
// Depends on ami_pkg.
module ami_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ami_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output ami_pkg::job_type head_job
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ami_pkg::job_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = mem_ff[rd_ff];
endmodule

// File: rtl/ami_back.sv
// Back part: six pipelined restoring dividers, one quotient bit per stage,
// then saturation and sign. Depends on ami_pkg.
module ami_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  ami_pkg::job_type              in_job,
   output logic                          out_valid,
   output logic [ami_pkg::TDATA_W-1:0]   out_data,
   output logic [ami_pkg::TUSER_W-1:0]   out_user
);
   localparam int L  = ami_pkg::LANES;
   localparam int RW = ami_pkg::REM_W;
   localparam int QW = ami_pkg::QUO_W;
   localparam int NS = ami_pkg::DIV_STEPS;

   ami_pkg::div_stage_type stg_ff [NS+1];
   ami_pkg::div_stage_type stg_in [NS+1];
   logic                          ov_ff, ov_in;
   logic [ami_pkg::TDATA_W-1:0]   od_ff, od_in;
   logic [ami_pkg::TUSER_W-1:0]   ou_ff, ou_in;

   always_comb begin
      stg_in[0].valid    = in_valid;
      stg_in[0].singular = in_job.singular;
      stg_in[0].det_mag  = in_job.det_mag;
      for (int j = 0; j < L; j++) begin
         stg_in[0].neg[j] = in_job.num_neg[j] ^ in_job.det_neg;
         stg_in[0].ovf[j] = {17'd0, in_job.num_mag[j]} >= {in_job.det_mag, 33'd0};
         stg_in[0].rem[j] = {17'd0, in_job.num_mag[j]};
         stg_in[0].quo[j] = '0;
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_step
      localparam int K = NS - s;
      logic [RW:0] dsh;
      logic [L-1:0][RW:0] diff;
      assign dsh = (RW+1)'(stg_ff[s-1].det_mag) << K;
      always_comb begin
         stg_in[s] = stg_ff[s-1];
         for (int j = 0; j < L; j++) begin
            diff[j] = {1'b0, stg_ff[s-1].rem[j]} - dsh;
            if (!diff[j][RW]) begin
               stg_in[s].rem[j]    = diff[j][RW-1:0];
               stg_in[s].quo[j][K] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [31:0] limit;
      logic [31:0] mag;
      logic        sat;
      logic        any_sat;
      any_sat = 1'b0;
      od_in   = '0;
      ov_in   = stg_ff[NS].valid;
      for (int j = 0; j < L; j++) begin
         limit = stg_ff[NS].neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         sat   = stg_ff[NS].ovf[j] || (stg_ff[NS].quo[j] > {1'b0, limit});
         mag   = sat ? limit : stg_ff[NS].quo[j][31:0];
         any_sat = any_sat | sat;
         od_in[j*32 +: 32] = stg_ff[NS].neg[j] ? 32'(-mag) : mag;
      end
      if (stg_ff[NS].singular) begin
         od_in = '0;
         ou_in = 2'b01;
      end else begin
         ou_in = {any_sat, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NS; s++) begin
         if (reset) begin
            stg_ff[s].valid <= 1'b0;
         end else if (enable) begin
            stg_ff[s].valid <= stg_in[s].valid;
         end
         if (enable) begin
            stg_ff[s].singular <= stg_in[s].singular;
            stg_ff[s].det_mag  <= stg_in[s].det_mag;
            stg_ff[s].neg      <= stg_in[s].neg;
            stg_ff[s].ovf      <= stg_in[s].ovf;
            stg_ff[s].rem      <= stg_in[s].rem;
            stg_ff[s].quo      <= stg_in[s].quo;
         end
      end
      if (enable) begin
         od_ff <= od_in;
         ou_ff <= ou_in;
      end
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (enable) begin
         ov_ff <= ov_in;
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_user  = ou_ff;
endmodule

// File: rtl/affine_matrix_inverse.sv
// Channel | dir | tdata                    | tuser
// req     | in  | m00 m01 m02 m10 m11 m12  | -
// rsp     | out | inv00..inv12             | singular overflow
// One matrix word per cycle when the response side does not stall; a word passes
// through 3 front stages, the queue memory, 34 divider stages and 1 output register.
// The divider retires one quotient bit per stage across six lanes.
// Reset is synchronous and clears only valid bits and the queue pointers and count.
// Front and back stall on their own; the queue absorbs the difference.
module affine_matrix_inverse #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // m00, m01, m02, m10, m11, m12
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,  // inv00, inv01, inv02, inv10, inv11, inv12
   output logic [1:0]   rsp_tuser   // singular, overflow
);
   logic             front_en, back_en, f_valid, q_full, q_empty, q_pop;
   ami_pkg::job_type f_job, q_job;

   assign front_en   = !(f_valid && q_full);
   assign back_en    = !rsp_tvalid || rsp_tready;
   assign q_pop      = back_en && !q_empty;
   assign req_tready = front_en;

   ami_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (front_en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_job   (f_job)
   );

   ami_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid && !q_full),
      .push_job (f_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (q_job)
   );

   ami_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (back_en),
      .in_valid  (!q_empty),
      .in_job    (q_job),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser)
   );
endmodule

// File: rtl/ami_checker.sv
// Port-level checks of the affine matrix inverse block, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ami_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   logic sat_seen;
   always_comb begin
      sat_seen = 1'b0;
      for (int j = 0; j < 6; j++) begin
         sat_seen = sat_seen || rsp_tdata[j*32 +: 32] == 32'h7FFF_FFFF
                             || rsp_tdata[j*32 +: 32] == 32'h8000_0000;
      end
   end

   `AMI_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `AMI_ASSERT_IMP(a_sing_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `AMI_ASSERT_IMP(a_sing_novf, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1])
   `AMI_ASSERT_IMP(a_ovf_sat, clock, reset, rsp_tvalid && rsp_tuser[1], sat_seen)
   `AMI_ASSERT_NXT(a_rst_idle, clock, 1'b0, reset, !rsp_tvalid)
endmodule

bind affine_matrix_inverse ami_checker u_ami_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
